FILE: hdl/fdf4_pkg.sv
// Shared constants, pipeline types and small arithmetic helpers for the F4 evaluator.
package fdf4_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ETA_W     = 24;
  localparam int OUT_W     = 46;

  // Magnitude of eta after saturation to +/-64, and the shift from Q.FRAC to Q.32.
  localparam int VABS_W = FRAC_BITS + 7;
  localparam int ARG_SH = 32 - FRAC_BITS;
  localparam int ARG_W  = VABS_W + ARG_SH;
  localparam int SQ_W   = 2 * VABS_W;
  localparam int S_W    = SQ_W - 1;
  localparam int YM_W   = ARG_W + 1;

  localparam int INNER_W = 43;
  localparam int MID_W   = 55;
  localparam int S_LO_W  = 23;
  localparam int PML_W   = INNER_W + S_LO_W;
  localparam int P_W     = OUT_W;
  localparam int SUM_W   = 33;
  localparam int D_W     = 33;
  localparam int TOP_W   = 32;
  localparam int NUM_W   = SUM_W + 5 + FRAC_BITS;
  localparam int HI_SH   = OUT_W - 32;

  localparam int TAYLOR_TERMS = 13;
  localparam int DIV_BITS     = 2;
  localparam int DIV_STAGES   = OUT_W / DIV_BITS;

  // Stage map: the step with index k builds stage k+1 from stage k.
  // The inner * s product is split in two halves over two steps.
  localparam int K_ARG       = 0;
  localparam int K_YM        = 1;
  localparam int K_T         = 2;
  localparam int K_TAY_LO    = 3;
  localparam int K_MID       = K_TAY_LO;
  localparam int K_P         = K_TAY_LO + 1;
  localparam int K_TAY_HI    = K_TAY_LO + 2 * (TAYLOR_TERMS - 1) - 1;
  localparam int K_EXP       = K_TAY_HI + 1;
  localparam int K_DIV_SETUP = K_EXP + 1;
  localparam int K_OVF       = K_DIV_SETUP + 1;
  localparam int K_DIV_LO    = K_OVF + 1;
  localparam int K_DIV_HI    = K_DIV_LO + DIV_STAGES - 1;
  localparam int N_STAGES    = K_DIV_HI + 2;

  localparam logic [SUM_W-1:0] ONE_Q32        = 33'h1_0000_0000;
  localparam logic [31:0]      LN2_Q32        = 32'd2977044472;
  localparam logic [32:0]      LOG2E_Q32      = 33'd6196328019;
  localparam logic [29:0]      C5_Q32         = 30'd858993459;
  localparam logic [34:0]      C3_Q32         = 35'd28259596317;
  localparam logic [37:0]      C1_Q32         = 38'd195238905355;
  localparam logic [32:0]      DAMP_Q32       = 33'd8368314280;
  localparam logic [31:0]      DEN_RATE_Q32   = 32'd3975851226;
  localparam logic [26:0]      DEN_WEIGHT_Q32 = 27'd123265561;
  localparam logic [ARG_W-1:0] LOW_EDGE_Q32   = ARG_W'(64'd4294967);
  localparam logic [ARG_W-1:0] MID_EDGE_Q32   = ARG_W'(64'd30 << 32);
  localparam logic signed [ETA_W-1:0] ETA_LIM = ETA_W'(64 << FRAC_BITS);
  localparam logic [OUT_W-1:0] OUT_MAX        = {OUT_W{1'b1}};

  typedef struct packed {
    logic             neg;
    logic             zero;
    logic [5:0]       sh;
    logic [ARG_W-1:0] arg;
    logic [YM_W-1:0]  ym;
    logic [31:0]      t;
    logic [31:0]      term;
    logic [31:0]      prod;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] ex;
  } exp_lane_t;

  typedef struct packed {
    logic               hi;
    logic               far;
    logic               neg;
    logic [VABS_W-1:0]  vabs;
    logic [S_W-1:0]     s;
    logic [INNER_W-1:0] inner;
    logic [PML_W-1:0]   pml;
    logic [MID_W-1:0]   mid;
    logic [P_W-1:0]     p;
    exp_lane_t [1:0]    lane;
    logic [D_W-1:0]     dvs;
    logic [TOP_W-1:0]   top;
    logic [OUT_W-1:0]   nlow;
    logic [D_W-1:0]     rem;
    logic [OUT_W-1:0]   quo;
    logic               ovf;
  } pipe_t;

  // floor(2^36 / d) for the Taylor divisors.
  function automatic logic [35:0] recip36(input int d);
    logic [35:0] r;
    case (d)
      2:       r = 36'd34359738368;
      3:       r = 36'd22906492245;
      4:       r = 36'd17179869184;
      5:       r = 36'd13743895347;
      6:       r = 36'd11453246122;
      7:       r = 36'd9817068105;
      8:       r = 36'd8589934592;
      9:       r = 36'd7635497415;
      10:      r = 36'd6871947673;
      11:      r = 36'd6247225157;
      12:      r = 36'd5726623061;
      13:      r = 36'd5286113595;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Exact floor(x / d): the reciprocal estimate is low by at most one.
  function automatic logic [31:0] div_small(input logic [31:0] x, input int d);
    logic [67:0] pr;
    logic [31:0] q0;
    logic [35:0] r;
    pr = 68'(x) * 68'(recip36(d));
    q0 = pr[67:36];
    r  = 36'(x) - 36'(q0) * 36'(d);
    return (r >= 36'(d)) ? q0 + 32'd1 : q0;
  endfunction

endpackage

FILE: hdl/fermi_dirac_f4_approx_unit.sv
// Throughput: one request per cycle while the skid entry is empty; the pipeline
// stalls while it is occupied. The 54-stage pipeline holds two 13-term exp
// series, two steps per term, and a 2-bit-per-stage divider.
// A two-entry output buffer lets the pipeline keep moving while one result waits.
// Reset clears the stage valid bits and the output buffer; datapath registers
// are not reset.
module fermi_dirac_f4_approx_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [fdf4_pkg::ETA_W-1:0] eta_q16_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [fdf4_pkg::OUT_W-1:0]      f4_q16_o
);

  localparam int LAST = fdf4_pkg::N_STAGES - 1;

  function automatic fdf4_pkg::pipe_t pipe_step(input int k, input fdf4_pkg::pipe_t x);
    fdf4_pkg::pipe_t y;
    logic [fdf4_pkg::VABS_W+32:0]      pa;
    logic [fdf4_pkg::VABS_W+31:0]      pb;
    logic [fdf4_pkg::ARG_W+32:0]       py;
    logic [29+fdf4_pkg::S_W:0]         pi;
    logic [fdf4_pkg::INNER_W+fdf4_pkg::S_W-1:0] pm;
    logic [fdf4_pkg::MID_W+fdf4_pkg::VABS_W-1:0] pp;
    logic [59:0]                       pw;
    logic [fdf4_pkg::NUM_W-1:0]        num;
    logic [fdf4_pkg::D_W-1:0]          den;
    logic [31:0]                       fp;
    logic [31:0]                       f;
    logic [7:0]                        ip;
    logic [8:0]                        shw;
    logic [fdf4_pkg::D_W:0]            r2;
    logic                              qb;
    int                                i;
    y = x;
    if (k == fdf4_pkg::K_ARG) begin
      y.s = fdf4_pkg::S_W'(fdf4_pkg::SQ_W'(x.vabs) * fdf4_pkg::SQ_W'(x.vabs));
      pa = $bits(pa)'(x.vabs) * $bits(pa)'(fdf4_pkg::DAMP_Q32);
      pb = $bits(pb)'(x.vabs) * $bits(pb)'(fdf4_pkg::DEN_RATE_Q32);
      y.lane[0].arg = x.hi ? fdf4_pkg::ARG_W'(pa >> fdf4_pkg::ARG_SH)
                           : {x.vabs, {fdf4_pkg::ARG_SH{1'b0}}};
      y.lane[1].arg = fdf4_pkg::ARG_W'(pb >> fdf4_pkg::ARG_SH);
      y.lane[0].neg = x.hi | x.neg;
      y.lane[1].neg = x.neg;
    end else if (k == fdf4_pkg::K_YM) begin
      for (int l = 0; l < 2; l++) begin
        py = $bits(py)'(x.lane[l].arg) * $bits(py)'(fdf4_pkg::LOG2E_Q32);
        y.lane[l].ym = fdf4_pkg::YM_W'(py >> 32);
      end
      pi = $bits(pi)'(fdf4_pkg::C5_Q32) * $bits(pi)'(x.s);
      y.inner = fdf4_pkg::INNER_W'(pi >> 32) + fdf4_pkg::INNER_W'(fdf4_pkg::C3_Q32);
    end else if (k == fdf4_pkg::K_T) begin
      for (int l = 0; l < 2; l++) begin
        fp = x.lane[l].ym[31:0];
        ip = x.lane[l].ym[fdf4_pkg::YM_W-1:32];
        // A negative exponent is split as -(ip + 1) + (1 - frac) when the fraction is nonzero.
        if (x.lane[l].neg) begin
          if (fp != 32'd0) begin
            f   = 32'd0 - fp;
            shw = 9'(ip) + 9'd1;
          end else begin
            f   = 32'd0;
            shw = 9'(ip);
          end
        end else begin
          f   = fp;
          shw = 9'(ip);
        end
        y.lane[l].zero = shw > 9'd63;
        y.lane[l].sh   = shw[5:0];
        y.lane[l].t    = 32'((64'(f) * 64'(fdf4_pkg::LN2_Q32)) >> 32);
        y.lane[l].term = y.lane[l].t;
        y.lane[l].sum  = fdf4_pkg::ONE_Q32 + fdf4_pkg::SUM_W'(y.lane[l].t);
      end
      pm    = $bits(pm)'(x.inner) * $bits(pm)'(x.s[fdf4_pkg::S_LO_W-1:0]);
      y.pml = fdf4_pkg::PML_W'(pm);
    end else if (k >= fdf4_pkg::K_TAY_LO && k <= fdf4_pkg::K_TAY_HI) begin
      if (k == fdf4_pkg::K_MID) begin
        pm    = $bits(pm)'(x.inner) * $bits(pm)'(x.s[fdf4_pkg::S_W-1:fdf4_pkg::S_LO_W]);
        pm    = (pm << fdf4_pkg::S_LO_W) + $bits(pm)'(x.pml);
        y.mid = fdf4_pkg::MID_W'(pm >> 32) + fdf4_pkg::MID_W'(fdf4_pkg::C1_Q32);
      end
      if (k == fdf4_pkg::K_P) begin
        pp  = $bits(pp)'(x.mid) * $bits(pp)'(x.vabs);
        y.p = fdf4_pkg::P_W'(pp >> 32);
      end
      if (((k - fdf4_pkg::K_TAY_LO) & 1) == 0) begin
        for (int l = 0; l < 2; l++) begin
          y.lane[l].prod = 32'((64'(x.lane[l].term) * 64'(x.lane[l].t)) >> 32);
        end
      end else begin
        i = ((k - fdf4_pkg::K_TAY_LO) >> 1) + 2;
        for (int l = 0; l < 2; l++) begin
          y.lane[l].term = fdf4_pkg::div_small(x.lane[l].prod, i);
          y.lane[l].sum  = x.lane[l].sum + fdf4_pkg::SUM_W'(y.lane[l].term);
        end
      end
    end else if (k == fdf4_pkg::K_EXP) begin
      // Positive arguments in use (eta up to 0.001) stay below 0.001 * log2(e); ip is zero.
      for (int l = 0; l < 2; l++) begin
        if (x.lane[l].neg) begin
          y.lane[l].ex = x.lane[l].zero ? '0 : x.lane[l].sum >> x.lane[l].sh;
        end else begin
          y.lane[l].ex = x.lane[l].sum;
        end
      end
    end else if (k == fdf4_pkg::K_DIV_SETUP) begin
      pw  = 60'(x.lane[1].ex) * 60'(fdf4_pkg::DEN_WEIGHT_Q32);
      den = fdf4_pkg::D_W'(fdf4_pkg::ONE_Q32) + fdf4_pkg::D_W'(pw >> 32);
      num = (fdf4_pkg::NUM_W'(x.lane[0].ex) * fdf4_pkg::NUM_W'(24)) << fdf4_pkg::FRAC_BITS;
      if (!x.hi) begin
        y.dvs  = den;
        y.top  = fdf4_pkg::TOP_W'(num >> fdf4_pkg::OUT_W);
        y.nlow = num[fdf4_pkg::OUT_W-1:0];
      end else if (x.far) begin
        // Beyond eta = 30 the polynomial passes through a divide by one.
        y.dvs  = fdf4_pkg::D_W'(1);
        y.top  = '0;
        y.nlow = x.p;
      end else begin
        y.dvs  = (x.lane[0].ex >= fdf4_pkg::ONE_Q32) ? fdf4_pkg::D_W'(1)
                                                      : fdf4_pkg::ONE_Q32 - x.lane[0].ex;
        y.top  = fdf4_pkg::TOP_W'(x.p >> fdf4_pkg::HI_SH);
        y.nlow = fdf4_pkg::OUT_W'({x.p, 32'd0});
      end
    end else if (k == fdf4_pkg::K_OVF) begin
      // A quotient of 2^46 or more saturates.
      y.ovf = fdf4_pkg::D_W'(x.top) >= x.dvs;
      y.rem = fdf4_pkg::D_W'(x.top);
      y.quo = '0;
    end else if (k >= fdf4_pkg::K_DIV_LO && k <= fdf4_pkg::K_DIV_HI) begin
      for (int b = 0; b < fdf4_pkg::DIV_BITS; b++) begin
        r2     = {y.rem, y.nlow[fdf4_pkg::OUT_W-1]};
        y.nlow = {y.nlow[fdf4_pkg::OUT_W-2:0], 1'b0};
        if (r2 >= {1'b0, y.dvs}) begin
          r2 = r2 - {1'b0, y.dvs};
          qb = 1'b1;
        end else begin
          qb = 1'b0;
        end
        y.rem = r2[fdf4_pkg::D_W-1:0];
        y.quo = {y.quo[fdf4_pkg::OUT_W-2:0], qb};
      end
    end
    return y;
  endfunction

  fdf4_pkg::pipe_t                  stage_q [fdf4_pkg::N_STAGES];
  fdf4_pkg::pipe_t                  stage_d [fdf4_pkg::N_STAGES];
  logic [fdf4_pkg::N_STAGES-1:0]    vld_q;
  logic signed [fdf4_pkg::ETA_W-1:0] eta_sat;
  logic [fdf4_pkg::ARG_W-1:0]       m_in;
  logic                             en;
  logic                             push;
  logic                             out_v_q;
  logic                             skid_v_q;
  logic [fdf4_pkg::OUT_W-1:0]       out_d_q;
  logic [fdf4_pkg::OUT_W-1:0]       skid_d_q;
  logic [fdf4_pkg::OUT_W-1:0]       res;

  always_comb begin
    if (eta_q16_i > fdf4_pkg::ETA_LIM) begin
      eta_sat = fdf4_pkg::ETA_LIM;
    end else if (eta_q16_i < -fdf4_pkg::ETA_LIM) begin
      eta_sat = -fdf4_pkg::ETA_LIM;
    end else begin
      eta_sat = eta_q16_i;
    end
    stage_d[0]      = '0;
    stage_d[0].neg  = eta_sat[fdf4_pkg::ETA_W-1];
    stage_d[0].vabs = eta_sat[fdf4_pkg::ETA_W-1] ? fdf4_pkg::VABS_W'(-eta_sat)
                                                 : fdf4_pkg::VABS_W'(eta_sat);
    m_in            = {stage_d[0].vabs, {fdf4_pkg::ARG_SH{1'b0}}};
    stage_d[0].hi   = !stage_d[0].neg && (m_in > fdf4_pkg::LOW_EDGE_Q32);
    stage_d[0].far  = stage_d[0].hi && (m_in > fdf4_pkg::MID_EDGE_Q32);
  end

  for (genvar k = 0; k < LAST; k++) begin : g_stage
    always_comb begin
      stage_d[k+1] = pipe_step(k, stage_q[k]);
    end
  end

  // The whole pipeline advances unless the skid entry is occupied.
  assign en         = !skid_v_q;
  assign in_ready_o = en;
  assign push       = en && vld_q[LAST];
  assign res        = stage_q[LAST].ovf ? fdf4_pkg::OUT_MAX : stage_q[LAST].quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAST-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= LAST; k++) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_v_q && !out_ready_i) begin
      if (push) begin
        skid_v_q <= 1'b1;
      end
    end else if (skid_v_q) begin
      out_v_q  <= 1'b1;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_v_q && !out_ready_i) begin
      if (push) begin
        skid_d_q <= res;
      end
    end else if (skid_v_q) begin
      out_d_q <= skid_d_q;
    end else if (push) begin
      out_d_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign f4_q16_o    = out_d_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held without a waiting result");

  a_last_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LAST] && en) |=> out_v_q)
    else $error("result leaving the pipeline was dropped");

  a_ovf_only_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[LAST] && stage_q[LAST].ovf) |-> stage_q[LAST].hi)
    else $error("quotient saturation outside the positive region");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_ready_i))
    else $error("skid entry filled without an output stall");

endmodule

FILE: tb/fermi_dirac_f4_approx_unit_tb.sv
// Self-checking testbench for the F4 evaluator: random and edge eta requests.
module fermi_dirac_f4_approx_unit_tb;

  localparam int ETA_W     = fdf4_pkg::ETA_W;
  localparam int OUT_W     = fdf4_pkg::OUT_W;
  localparam int FRAC_BITS = fdf4_pkg::FRAC_BITS;
  localparam logic signed [ETA_W-1:0] ETA_LIM = fdf4_pkg::ETA_LIM;

  typedef longint unsigned u64_t;

  class F4Scoreboard;
    u64_t expected_f4[$];
    int   mismatches;
    int   orphans;

    function u64_t mul_sh(u64_t a, u64_t b, int sh);
      logic [127:0] p;
      logic [127:0] q;
      p = {64'd0, a} * {64'd0, b};
      if (sh == 0) return (p[127:64] != 0) ? '1 : p[63:0];
      if (sh > 63) sh = 63;
      q = p >> sh;
      return (q[127:64] != 0) ? '1 : q[63:0];
    endfunction

    // 2^(f / 2^32) in Q.32 through a 13-term series of exp(f ln 2).
    function u64_t pow2_fraction(u64_t f);
      u64_t t, sum, term;
      t = mul_sh(f & 64'hFFFF_FFFF, 64'd2977044472, 32);
      sum = 64'd1 << 32;
      term = 64'd1 << 32;
      for (int i = 1; i <= 13; i++) begin
        term = mul_sh(term, t, 32) / u64_t'(i);
        sum += term;
      end
      return sum;
    endfunction

    function u64_t exp_fix(bit neg, u64_t m);
      u64_t ym, ip, fp, sh, f;
      ym = mul_sh(m, 64'd6196328019, 32);
      ip = ym >> 32;
      fp = ym & 64'hFFFF_FFFF;
      if (neg) begin
        sh = ip;
        f = 0;
        if (fp != 0) begin
          sh = ip + 1;
          f = (64'd1 << 32) - fp;
        end
        if (sh > 63) return 0;
        return pow2_fraction(f) >> sh;
      end
      if (ip > 30) ip = 30;
      return pow2_fraction(fp) << ip;
    endfunction

    function u64_t quintic_poly(u64_t a);
      u64_t s, inner, mid;
      s = mul_sh(a, a, 32);
      inner = mul_sh(64'd858993459, s, 32) + 64'd28259596317;
      mid = mul_sh(inner, s, 32) + 64'd195238905355;
      return mul_sh(mid, a, 64 - FRAC_BITS);
    endfunction

    function u64_t div_fix(u64_t p, u64_t d);
      u64_t qh, r;
      qh = p / d;
      r = p % d;
      if (qh >= (64'd1 << 32)) return '1;
      return (qh << 32) + ((r << 32) / d);
    endfunction

    function u64_t f4_of(logic signed [ETA_W-1:0] eta);
      longint v, e, lim;
      u64_t a, p, ex, d, m, e1, e2, den, r;
      bit neg;
      lim = longint'(64) << FRAC_BITS;
      v = eta;
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      e = v * (longint'(1) << (32 - FRAC_BITS));
      if (e > 4294967) begin
        a = u64_t'(e);
        p = quintic_poly(a);
        if (a <= (64'd30 << 32)) begin
          ex = exp_fix(1'b1, mul_sh(a, 64'd8368314280, 32));
          d = (ex >= (64'd1 << 32)) ? 64'd1 : (64'd1 << 32) - ex;
          r = div_fix(p, d);
        end else begin
          r = p;
        end
      end else begin
        neg = e < 0;
        m = neg ? u64_t'(-e) : u64_t'(e);
        e1 = exp_fix(neg, m);
        e2 = exp_fix(neg, mul_sh(m, 64'd3975851226, 32));
        den = (64'd1 << 32) + mul_sh(e2, 64'd123265561, 32);
        r = ((64'd24 * e1) << FRAC_BITS) / den;
      end
      if (r > ((64'd1 << 46) - 1)) r = (64'd1 << 46) - 1;
      return r;
    endfunction

    function void note_request(logic signed [ETA_W-1:0] eta);
      expected_f4.push_back(f4_of(eta));
    endfunction

    function void check_result(logic [OUT_W-1:0] f4);
      u64_t want;
      if (expected_f4.size() == 0) begin
        orphans++;
        if (mismatches + orphans <= 10) $display("unexpected result f4=%0d", f4);
        return;
      end
      want = expected_f4.pop_front();
      if (u64_t'(f4) != want) begin
        mismatches++;
        if (mismatches + orphans <= 10)
          $display("f4 mismatch: expected %0d, got %0d", want, f4);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic signed [ETA_W-1:0] eta_q16_i = '0;
  logic in_ready_o, out_valid_o;
  logic [OUT_W-1:0] f4_q16_o;

  F4Scoreboard sb = new();
  bit hold_out = 1'b0;
  bit burst = 1'b0;

  always #5 clk_i = ~clk_i;

  fermi_dirac_f4_approx_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .eta_q16_i(eta_q16_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .f4_q16_o(f4_q16_o)
  );

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_eta(logic signed [ETA_W-1:0] eta);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    eta_q16_i <= eta;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(eta);
  endtask

  function logic signed [ETA_W-1:0] random_eta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return ETA_W'($urandom());
    if (r < 60) return ETA_W'($urandom_range(0, 45 << 16)) - ETA_W'(12 << 16);
    if (r < 75) return ETA_W'($urandom_range(0, 400)) - ETA_W'(200);
    if (r < 87) return ETA_W'($urandom_range(0, 4 << 16)) + ETA_W'(28 << 16);
    if (r < 94) return ETA_W'($urandom_range(0, 4 << 16)) + ETA_W'(62 << 16);
    return -(ETA_W'($urandom_range(0, 70 << 16)));
  endfunction

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    int r;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(f4_q16_o);
      if (hold_out) begin
        out_ready_i <= 1'b0;
        hold_out = 1'b0;
        repeat (300) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (burst) begin
        out_ready_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r > 97) begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk_i);
        end else begin
          out_ready_i <= (r < 70);
        end
      end
    end
  end

  initial begin
    logic signed [ETA_W-1:0] directed[$];
    directed = '{24'sh800000, 24'sh7FFFFF, ETA_LIM, -ETA_LIM, ETA_LIM + 1, -ETA_LIM - 1,
                 0, 1, -1, 65, 66, 67, -65, 30 << 16, (30 << 16) + 1, (30 << 16) - 1,
                 1 << 16, -(1 << 16), -(20 << 16), -(40 << 16), 24'sh555555, 24'shAAAAAA,
                 (63 << 16) + 1234};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_eta(directed[i]);

    // Receiver blocks while requests keep arriving, so the pipeline backs up.
    hold_out = 1'b1;
    burst = 1'b1;
    repeat (120) send_eta(random_eta());
    burst = 1'b0;
    repeat (250) send_eta(random_eta());

    // Sender pauses until the pipeline has drained completely.
    in_valid_i <= 1'b0;
    while (sb.expected_f4.size() != 0) @(posedge clk_i);

    burst = 1'b1;
    repeat (100) send_eta(random_eta());
    burst = 1'b0;
    repeat (280) send_eta(random_eta());
    in_valid_i <= 1'b0;

    while (sb.expected_f4.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.orphans == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: fermi_dirac_f4_approx_unit.f
hdl/fdf4_pkg.sv
hdl/fermi_dirac_f4_approx_unit.sv
tb/fermi_dirac_f4_approx_unit_tb.sv
